FILE: design/zcc_pkg.sv
// shared codes, constants and helpers for the zlib container checker
package zcc_pkg;

    localparam logic [1:0] FUNC_CONTAINER = 2'd0;
    localparam logic [1:0] FUNC_PAYLOAD   = 2'd1;
    localparam logic [1:0] FUNC_RESTART   = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_FCHECK   = 3'd2;
    localparam logic [2:0] ST_METHOD   = 3'd3;
    localparam logic [2:0] ST_CINFO    = 3'd4;
    localparam logic [2:0] ST_DICT     = 3'd5;
    localparam logic [2:0] ST_CHECKSUM = 3'd6;
    localparam logic [2:0] ST_SEQUENCE = 3'd7;

    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [15:0] ADLER_INIT = 16'd1;
    localparam logic [3:0]  CM_DEFLATE = 4'd8;
    localparam logic [3:0]  CINFO_MAX  = 4'd7;

    // header word divisible by 31: 32 is 1 mod 31, so fold 5-bit digits
    function automatic logic fcheck_ok(input logic [15:0] word);
        logic [6:0] digit_sum;
        logic [5:0] folded;
        begin
            digit_sum = {2'b0, word[4:0]} + {2'b0, word[9:5]} + {2'b0, word[14:10]}
                      + {6'b0, word[15]};
            folded    = {1'b0, digit_sum[4:0]} + {4'b0, digit_sum[6:5]};
            fcheck_ok = (folded == 6'd0) || (folded == 6'd31);
        end
    endfunction

endpackage

FILE: design/zlib_container_checker.sv
// zlib wrapper checker: header checks, adler-32 over payload, trailer compare
//
//  channel | ports                          | role
//  --------+--------------------------------+--------------------------------
//  s_      | s_valid s_ready s_func          | container bytes, payload bytes,
//          | s_data_byte                     | restart requests
//  m_      | m_valid m_ready m_status        | one result per input transfer
//          | m_window_code m_level_code      |
//          | m_running_checksum              |
//
// one transfer per cycle sustained while m_ready is high; a result follows its transfer
// through the input register, then the result register with the header and adler-32 logic between
// aresetn is synchronous; both stages empty and all checker state at reset values
// while m_ready is low the input register keeps taking one more transfer, then
// s_ready drops until the result register drains
module zlib_container_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_window_code,
    output logic [1:0]  m_level_code,
    output logic [31:0] m_running_checksum
);

    typedef enum logic [2:0] {
        PH_CMF,
        PH_FLG,
        PH_DICT,
        PH_BODY,
        PH_TRAIL,
        PH_DONE,
        PH_FAILED
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  count_reg, count_next;
    logic [7:0]  cmf_reg, cmf_next;
    logic        dict_reg, dict_next;
    logic [3:0]  window_reg, window_next;
    logic [1:0]  level_reg, level_next;
    logic [15:0] sum_low_reg, sum_low_next;
    logic [15:0] sum_high_reg, sum_high_next;
    logic [31:0] trailer_reg, trailer_next;

    logic        in_valid_reg;
    logic [1:0]  in_func_reg;
    logic [7:0]  in_data_reg;

    logic        m_valid_reg;
    logic [2:0]  status_reg, status_next;
    logic [3:0]  window_out_reg;
    logic [1:0]  level_out_reg;
    logic [31:0] checksum_out_reg;

    logic        advance;
    logic        seq_fail;
    logic [16:0] low_sum;
    logic [15:0] low_upd;
    logic [16:0] high_sum;
    logic [15:0] high_upd;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid            = m_valid_reg;
    assign m_status           = status_reg;
    assign m_window_code      = window_out_reg;
    assign m_level_code       = level_out_reg;
    assign m_running_checksum = checksum_out_reg;

    // adler-32 step with conditional subtract
    always_comb begin
        low_sum  = {1'b0, sum_low_reg} + {9'b0, in_data_reg};
        low_upd  = (low_sum >= zcc_pkg::ADLER_MOD) ? 16'(low_sum - zcc_pkg::ADLER_MOD)
                                                   : low_sum[15:0];
        high_sum = {1'b0, sum_high_reg} + {1'b0, low_upd};
        high_upd = (high_sum >= zcc_pkg::ADLER_MOD) ? 16'(high_sum - zcc_pkg::ADLER_MOD)
                                                    : high_sum[15:0];
    end

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        cmf_next      = cmf_reg;
        dict_next     = dict_reg;
        window_next   = window_reg;
        level_next    = level_reg;
        sum_low_next  = sum_low_reg;
        sum_high_next = sum_high_reg;
        trailer_next  = trailer_reg;
        status_next   = zcc_pkg::ST_OK;
        seq_fail      = 1'b0;
        case (phase_reg)
            PH_CMF: begin
                if (in_func_reg == zcc_pkg::FUNC_CONTAINER) begin
                    cmf_next   = in_data_reg;
                    phase_next = PH_FLG;
                end else begin
                    seq_fail = 1'b1;
                end
            end
            PH_FLG: begin
                if (in_func_reg == zcc_pkg::FUNC_CONTAINER) begin
                    window_next = cmf_reg[7:4];
                    level_next  = in_data_reg[7:6];
                    dict_next   = in_data_reg[5];
                    if (!zcc_pkg::fcheck_ok({cmf_reg, in_data_reg})) begin
                        phase_next  = PH_FAILED;
                        status_next = zcc_pkg::ST_FCHECK;
                    end else if (cmf_reg[3:0] != zcc_pkg::CM_DEFLATE) begin
                        phase_next  = PH_FAILED;
                        status_next = zcc_pkg::ST_METHOD;
                    end else if (cmf_reg[7:4] > zcc_pkg::CINFO_MAX) begin
                        phase_next  = PH_FAILED;
                        status_next = zcc_pkg::ST_CINFO;
                    end else begin
                        count_next = 2'd0;
                        phase_next = in_data_reg[5] ? PH_DICT : PH_BODY;
                    end
                end else begin
                    seq_fail = 1'b1;
                end
            end
            PH_DICT: begin
                if (in_func_reg == zcc_pkg::FUNC_CONTAINER) begin
                    if (count_reg == 2'd3) begin
                        phase_next  = PH_FAILED;
                        status_next = zcc_pkg::ST_DICT;
                    end else begin
                        count_next = count_reg + 2'd1;
                    end
                end else begin
                    seq_fail = 1'b1;
                end
            end
            PH_BODY: begin
                if (in_func_reg == zcc_pkg::FUNC_PAYLOAD) begin
                    sum_low_next  = low_upd;
                    sum_high_next = high_upd;
                end else if (in_func_reg == zcc_pkg::FUNC_CONTAINER) begin
                    trailer_next = {24'd0, in_data_reg};
                    count_next   = 2'd1;
                    phase_next   = PH_TRAIL;
                end else begin
                    seq_fail = 1'b1;
                end
            end
            PH_TRAIL: begin
                if (in_func_reg == zcc_pkg::FUNC_CONTAINER) begin
                    trailer_next = {trailer_reg[23:0], in_data_reg};
                    if (count_reg != 2'd3) begin
                        count_next = count_reg + 2'd1;
                    end else begin
                        count_next = 2'd0;
                        if ({trailer_reg[23:0], in_data_reg} != {sum_high_reg, sum_low_reg})
                        begin
                            phase_next  = PH_FAILED;
                            status_next = zcc_pkg::ST_CHECKSUM;
                        end else begin
                            phase_next  = PH_DONE;
                            status_next = zcc_pkg::ST_COMPLETE;
                        end
                    end
                end else begin
                    seq_fail = 1'b1;
                end
            end
            PH_DONE: begin
                if (in_func_reg == zcc_pkg::FUNC_RESTART) begin
                    phase_next    = PH_CMF;
                    count_next    = 2'd0;
                    cmf_next      = 8'd0;
                    dict_next     = 1'b0;
                    window_next   = 4'd0;
                    level_next    = 2'd0;
                    sum_low_next  = zcc_pkg::ADLER_INIT;
                    sum_high_next = 16'd0;
                    trailer_next  = 32'd0;
                end else begin
                    seq_fail = 1'b1;
                end
            end
            PH_FAILED: begin
                status_next = zcc_pkg::ST_SEQUENCE;
            end
            default: begin
                seq_fail = 1'b1;
            end
        endcase
        if (seq_fail) begin
            phase_next  = PH_FAILED;
            status_next = zcc_pkg::ST_SEQUENCE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= PH_CMF;
            count_reg    <= 2'd0;
            cmf_reg      <= 8'd0;
            dict_reg     <= 1'b0;
            window_reg   <= 4'd0;
            level_reg    <= 2'd0;
            sum_low_reg  <= zcc_pkg::ADLER_INIT;
            sum_high_reg <= 16'd0;
            trailer_reg  <= 32'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
                in_func_reg  <= s_func;
                in_data_reg  <= s_data_byte;
            end
            if (advance) begin
                phase_reg        <= phase_next;
                count_reg        <= count_next;
                cmf_reg          <= cmf_next;
                dict_reg         <= dict_next;
                window_reg       <= window_next;
                level_reg        <= level_next;
                sum_low_reg      <= sum_low_next;
                sum_high_reg     <= sum_high_next;
                trailer_reg      <= trailer_next;
                m_valid_reg      <= 1'b1;
                status_reg       <= status_next;
                window_out_reg   <= window_next;
                level_out_reg    <= level_next;
                checksum_out_reg <= {sum_high_next, sum_low_next};
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: design/zcc_checker.sv
// port-level assertions for the zlib container checker, bound to the top level
module zcc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [3:0]  m_window_code,
    input logic [1:0]  m_level_code,
    input logic [31:0] m_running_checksum
);

    logic failed_seen_reg;

    // sticky once an error result has been transferred
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            failed_seen_reg <= 1'b0;
        end else if (m_valid && m_ready && (m_status != zcc_pkg::ST_OK)
                     && (m_status != zcc_pkg::ST_COMPLETE)) begin
            failed_seen_reg <= 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_running_checksum) && $stable(m_window_code)
            && $stable(m_level_code))
        else $error("stalled result changed");

    a_failed_locks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && failed_seen_reg |-> m_status == zcc_pkg::ST_SEQUENCE)
        else $error("result after failure is not a sequence error");

    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_running_checksum[15:0]} < zcc_pkg::ADLER_MOD)
            && ({1'b0, m_running_checksum[31:16]} < zcc_pkg::ADLER_MOD))
        else $error("checksum half out of modulus range");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result stage");

endmodule

bind zlib_container_checker zcc_checker u_zcc_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_status           (m_status),
    .m_window_code      (m_window_code),
    .m_level_code       (m_level_code),
    .m_running_checksum (m_running_checksum)
);

FILE: tb/zlib_container_checker_tb.sv
// testbench for zlib_container_checker: zlib wrapper streams checked against a built-in predictor
module zlib_container_checker_tb;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1000;

    typedef enum logic [2:0] {
        WAIT_CMF, WAIT_FLG, DICT_ID, BODY, TRAILER, DONE, FAILED
    } wrapper_phase_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  window;
        logic [1:0]  level;
        logic [31:0] checksum;
    } wrapper_result_t;

    class wrapper_tracker;
        wrapper_phase_t phase;
        logic [1:0]  count;
        logic [7:0]  cmf_byte;
        logic        fdict;
        logic [3:0]  window;
        logic [1:0]  level;
        logic [15:0] adler_a;
        logic [15:0] adler_b;
        logic [31:0] trailer_word;
        wrapper_result_t expected_results[$];
        int errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase = WAIT_CMF;
            count = 0;
            cmf_byte = 0;
            fdict = 0;
            window = 0;
            level = 0;
            adler_a = zcc_pkg::ADLER_INIT;
            adler_b = 0;
            trailer_word = 0;
        endfunction

        function logic [31:0] adler_word();
            return {adler_b, adler_a};
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void add_payload(logic [7:0] b);
            logic [16:0] sum;
            sum = {1'b0, adler_a} + {9'd0, b};
            if (sum >= zcc_pkg::ADLER_MOD) sum = sum - zcc_pkg::ADLER_MOD;
            adler_a = sum[15:0];
            sum = {1'b0, adler_b} + {1'b0, adler_a};
            if (sum >= zcc_pkg::ADLER_MOD) sum = sum - zcc_pkg::ADLER_MOD;
            adler_b = sum[15:0];
        endfunction

        function logic [2:0] advance(logic [1:0] f, logic [7:0] b);
            logic [15:0] word;
            if (phase == FAILED) return zcc_pkg::ST_SEQUENCE;
            case (phase)
                WAIT_CMF: if (f == zcc_pkg::FUNC_CONTAINER) begin
                    cmf_byte = b;
                    phase = WAIT_FLG;
                    return zcc_pkg::ST_OK;
                end
                WAIT_FLG: if (f == zcc_pkg::FUNC_CONTAINER) begin
                    window = cmf_byte[7:4];
                    level = b[7:6];
                    fdict = b[5];
                    word = {cmf_byte, b};
                    if (word % 31 != 0) begin
                        phase = FAILED;
                        return zcc_pkg::ST_FCHECK;
                    end
                    if (cmf_byte[3:0] != zcc_pkg::CM_DEFLATE) begin
                        phase = FAILED;
                        return zcc_pkg::ST_METHOD;
                    end
                    if (window > zcc_pkg::CINFO_MAX) begin
                        phase = FAILED;
                        return zcc_pkg::ST_CINFO;
                    end
                    count = 0;
                    phase = fdict ? DICT_ID : BODY;
                    return zcc_pkg::ST_OK;
                end
                DICT_ID: if (f == zcc_pkg::FUNC_CONTAINER) begin
                    if (count == 2'd3) begin
                        phase = FAILED;
                        return zcc_pkg::ST_DICT;
                    end
                    count = count + 1;
                    return zcc_pkg::ST_OK;
                end
                BODY: begin
                    if (f == zcc_pkg::FUNC_PAYLOAD) begin
                        add_payload(b);
                        return zcc_pkg::ST_OK;
                    end
                    if (f == zcc_pkg::FUNC_CONTAINER) begin
                        trailer_word = {24'd0, b};
                        count = 1;
                        phase = TRAILER;
                        return zcc_pkg::ST_OK;
                    end
                end
                TRAILER: if (f == zcc_pkg::FUNC_CONTAINER) begin
                    trailer_word = {trailer_word[23:0], b};
                    if (count < 2'd3) begin
                        count = count + 1;
                        return zcc_pkg::ST_OK;
                    end
                    count = 0;
                    if (trailer_word != adler_word()) begin
                        phase = FAILED;
                        return zcc_pkg::ST_CHECKSUM;
                    end
                    phase = DONE;
                    return zcc_pkg::ST_COMPLETE;
                end
                DONE: if (f == zcc_pkg::FUNC_RESTART) begin
                    clear();
                    return zcc_pkg::ST_OK;
                end
                default: ;
            endcase
            phase = FAILED;
            return zcc_pkg::ST_SEQUENCE;
        endfunction

        function void note_transfer(logic [1:0] f, logic [7:0] b);
            wrapper_result_t r;
            r.status = advance(f, b);
            r.window = window;
            r.level = level;
            r.checksum = adler_word();
            expected_results.push_back(r);
        endfunction

        function void check_result(wrapper_result_t got);
            wrapper_result_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d checksum %h",
                         $time, got.status, got.checksum);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.window !== want.window) begin
                $display("%0t: window_code expected %0d actual %0d",
                         $time, want.window, got.window);
                errors++;
            end
            if (got.level !== want.level) begin
                $display("%0t: level_code expected %0d actual %0d",
                         $time, want.level, got.level);
                errors++;
            end
            if (got.checksum !== want.checksum) begin
                $display("%0t: running_checksum expected %h actual %h",
                         $time, want.checksum, got.checksum);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = zcc_pkg::FUNC_CONTAINER;
    logic [7:0]  s_data_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [3:0]  m_window_code;
    logic [1:0]  m_level_code;
    logic [31:0] m_running_checksum;

    wrapper_tracker tracker = new();
    bit calm = 1'b0;
    int transfers_sent = 0;
    int cycles = 0;

    zlib_container_checker uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_data_byte(s_data_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_window_code(m_window_code),
        .m_level_code(m_level_code),
        .m_running_checksum(m_running_checksum)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 21);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result({m_status, m_window_code, m_level_code, m_running_checksum});
    end

    task automatic send(logic [1:0] f, logic [7:0] b);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_transfer(f, b);
        transfers_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] good_flg(logic [7:0] cmf, logic [1:0] lvl, logic fd);
        logic [15:0] base;
        logic [4:0]  fc;
        base = {cmf, lvl, fd, 5'd0};
        fc = 5'((31 - base % 31) % 31);
        return {lvl, fd, fc};
    endfunction

    task automatic send_header(logic [3:0] cinfo, logic [1:0] lvl, logic fd);
        logic [7:0] cmf;
        cmf = {cinfo, zcc_pkg::CM_DEFLATE};
        send(zcc_pkg::FUNC_CONTAINER, cmf);
        send(zcc_pkg::FUNC_CONTAINER, good_flg(cmf, lvl, fd));
    endtask

    task automatic send_payload(int n, bit heavy);
        for (int i = 0; i < n; i++)
            send(zcc_pkg::FUNC_PAYLOAD, heavy ? 8'($urandom_range(240, 255)) : 8'($urandom));
    endtask

    task automatic send_trailer(logic [31:0] w);
        send(zcc_pkg::FUNC_CONTAINER, w[31:24]);
        send(zcc_pkg::FUNC_CONTAINER, w[23:16]);
        send(zcc_pkg::FUNC_CONTAINER, w[15:8]);
        send(zcc_pkg::FUNC_CONTAINER, w[7:0]);
    endtask

    task automatic send_restart();
        send(zcc_pkg::FUNC_RESTART, 8'($urandom));
    endtask

    task automatic send_stream(bit long_body);
        send_header(4'($urandom_range(0, 7)), 2'($urandom), 1'b0);
        if (long_body)
            send_payload($urandom_range(260, 330), 1'b1);
        else
            send_payload($urandom_range(0, 24), 1'b0);
        send_trailer(tracker.adler_word());
    endtask

    task automatic send_broken_stream();
        logic [7:0]  cmf;
        logic [7:0]  flg;
        logic [31:0] w;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind != 6) send_restart();
        case (kind)
            0: begin
                // header word not divisible by 31
                cmf = 8'($urandom);
                flg = 8'($urandom);
                while ({cmf, flg} % 31 == 0) flg = 8'($urandom);
                send(zcc_pkg::FUNC_CONTAINER, cmf);
                send(zcc_pkg::FUNC_CONTAINER, flg);
            end
            1: begin
                cmf = {4'($urandom_range(0, 7)), 4'($urandom)};
                while (cmf[3:0] == zcc_pkg::CM_DEFLATE) cmf[3:0] = 4'($urandom);
                send(zcc_pkg::FUNC_CONTAINER, cmf);
                send(zcc_pkg::FUNC_CONTAINER, good_flg(cmf, 2'($urandom), 1'($urandom)));
            end
            2: send_header(4'($urandom_range(8, 15)), 2'($urandom), 1'($urandom));
            3: begin
                send_header(4'($urandom_range(0, 7)), 2'($urandom), 1'b1);
                for (int i = 0; i < 4; i++) send(zcc_pkg::FUNC_CONTAINER, 8'($urandom));
            end
            4: begin
                send_header(4'($urandom_range(0, 7)), 2'($urandom), 1'b0);
                send_payload($urandom_range(0, 8), 1'b0);
                w = tracker.adler_word() ^ (32'd1 << $urandom_range(0, 31));
                send_trailer(w);
            end
            5: send(zcc_pkg::FUNC_PAYLOAD, 8'($urandom));
            6: send(zcc_pkg::FUNC_CONTAINER, 8'($urandom));
            7: begin
                send_header(4'($urandom_range(0, 7)), 2'($urandom), 1'b0);
                send_payload($urandom_range(0, 4), 1'b0);
                send_restart();
            end
            8: begin
                send_header(4'($urandom_range(0, 7)), 2'($urandom), 1'b0);
                send_payload($urandom_range(0, 4), 1'b0);
                send(FUNC_UNUSED, 8'($urandom));
            end
            default: begin
                send_header(4'($urandom_range(0, 7)), 2'($urandom), 1'b0);
                send_payload($urandom_range(0, 4), 1'b0);
                send(zcc_pkg::FUNC_CONTAINER, 8'($urandom));
                send(zcc_pkg::FUNC_CONTAINER, 8'($urandom));
                send(zcc_pkg::FUNC_PAYLOAD, 8'($urandom));
            end
        endcase
    endtask

    initial begin
        bit paused;
        bit first_random;
        paused = 1'b0;
        first_random = 1'b1;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // widest window, top level, payload extremes
        send_header(4'd7, 2'd3, 1'b0);
        send(zcc_pkg::FUNC_PAYLOAD, 8'h00);
        send(zcc_pkg::FUNC_PAYLOAD, 8'hFF);
        send(zcc_pkg::FUNC_PAYLOAD, 8'h80);
        send(zcc_pkg::FUNC_PAYLOAD, 8'h01);
        send_trailer(tracker.adler_word());
        send_restart();
        // empty body: trailer follows the header directly
        send_header(4'd0, 2'd0, 1'b0);
        send_trailer(tracker.adler_word());
        send_restart();
        send_header(4'd3, 2'd1, 1'b0);
        send_payload(2, 1'b0);
        send_trailer(tracker.adler_word());

        wait_drained();

        while (transfers_sent < RANDOM_ITEMS) begin
            calm = (transfers_sent >= 400 && transfers_sent < 600);
            if (!paused && transfers_sent >= 700) begin
                wait_drained();
                paused = 1'b1;
            end
            send_restart();
            send_stream(first_random || $urandom_range(7) == 0);
            first_random = 1'b0;
        end
        calm = 1'b0;

        // one broken stream locks the block, later requests must all answer sequence
        send_broken_stream();
        for (int i = 0; i < 12; i++)
            send(2'($urandom_range(0, 3)), 8'($urandom));

        wait_drained();
        repeat (8) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
design/zcc_pkg.sv
design/zlib_container_checker.sv
design/zcc_checker.sv
tb/zlib_container_checker_tb.sv
